@@ hdl/assert_macros.svh @@
// Assertion shorthands shared by the RTL modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define SPW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/spw_pkg.sv @@
package spw_pkg;

    localparam int ROTATION_STEPS_DEF = 16;
    localparam int MAX_STEPS          = 24;
    localparam int STEP_IDX_W         = 5;

    localparam int RANGE_W   = 16;
    localparam int BEAR_W    = 17;
    localparam int COORD_W   = 24;
    localparam int HEAD_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_ORIGIN = 1'b1;

    localparam logic [CFG_W-1:0] MIN_RANGE_RST   = 16'd26;
    localparam logic [CFG_W-1:0] NEAR_ORIGIN_RST = 16'd51;

    localparam int ANG_W   = 31;
    localparam int XY_W    = 36;
    localparam int X0_W    = 32;
    localparam int BPROD_W = 45;
    localparam int RPROD_W = 46;
    localparam int LOC_W   = XY_W - 16;
    localparam int SUM_W   = COORD_W + 1;

    localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74961321;
    localparam logic [29:0]        INV_GAIN_Q30   = 30'd652032874;

    localparam logic signed [ANG_W-1:0] ANG_PI       = 31'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI  = 31'sd26353589;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI   = 31'sd105414358;
    localparam logic signed [ANG_W-1:0] ANG_THREE_PI = 31'sd158121537;
    localparam logic signed [ANG_W-1:0] ANG_FOUR_PI  = 31'sd210828716;

    localparam logic signed [BPROD_W-1:0] BEAR_RND = 45'sd16384;
    localparam logic signed [XY_W-1:0]    LOC_RND  = 36'sd32768;

    localparam logic signed [SUM_W-1:0] SAT_MAX = 25'sd8388607;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -25'sd8388608;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic signed [COORD_W-1:0] rz;
    } side_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
        side_t                   side;
    } rot_t;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [STEP_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 31'sd13176795;
                5'd1:    v = 31'sd7778716;
                5'd2:    v = 31'sd4110060;
                5'd3:    v = 31'sd2086331;
                5'd4:    v = 31'sd1047214;
                5'd5:    v = 31'sd524117;
                5'd6:    v = 31'sd262123;
                5'd7:    v = 31'sd131069;
                5'd8:    v = 31'sd65536;
                5'd9:    v = 31'sd32768;
                5'd10:   v = 31'sd16384;
                5'd11:   v = 31'sd8192;
                5'd12:   v = 31'sd4096;
                5'd13:   v = 31'sd2048;
                5'd14:   v = 31'sd1024;
                5'd15:   v = 31'sd512;
                5'd16:   v = 31'sd256;
                5'd17:   v = 31'sd128;
                5'd18:   v = 31'sd64;
                5'd19:   v = 31'sd32;
                5'd20:   v = 31'sd16;
                5'd21:   v = 31'sd8;
                5'd22:   v = 31'sd4;
                5'd23:   v = 31'sd2;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/spw_front.sv @@
`include "assert_macros.svh"

module spw_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_v,
    input  logic [spw_pkg::RANGE_W-1:0]         range_dist,
    input  logic signed [spw_pkg::BEAR_W-1:0]   bearing_deg,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_x,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_y,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_z,
    input  logic signed [spw_pkg::HEAD_W-1:0]   heading,
    input  logic [spw_pkg::CFG_W-1:0]           min_range,
    output logic                                out_v,
    output spw_pkg::rot_t                       out_rot
);

    logic signed [spw_pkg::BPROD_W-1:0] bearing_ext;
    logic signed [spw_pkg::BPROD_W-1:0] bprod_next;
    logic [spw_pkg::RPROD_W-1:0]        range_ext;
    logic [spw_pkg::RPROD_W-1:0]        rprod;
    spw_pkg::side_t                     side1_next;

    logic                               v1_reg;
    logic signed [spw_pkg::BPROD_W-1:0] bprod_reg;
    logic [spw_pkg::X0_W-1:0]           x1_reg;
    logic signed [spw_pkg::HEAD_W-1:0]  hd1_reg;
    spw_pkg::side_t                     side1_reg;

    logic signed [spw_pkg::BPROD_W-1:0] hd_ext;
    logic signed [spw_pkg::BPROD_W-1:0] asum;
    logic signed [spw_pkg::ANG_W-1:0]   ang2_next;

    logic                               v2_reg;
    logic signed [spw_pkg::ANG_W-1:0]   ang2_reg;
    logic [spw_pkg::X0_W-1:0]           x2_reg;
    spw_pkg::side_t                     side2_reg;

    logic signed [spw_pkg::ANG_W-1:0]   ang3_next;

    logic                               v3_reg;
    logic signed [spw_pkg::ANG_W-1:0]   ang3_reg;
    logic [spw_pkg::X0_W-1:0]           x3_reg;
    spw_pkg::side_t                     side3_reg;

    logic signed [spw_pkg::XY_W-1:0]    x3_ext;
    spw_pkg::rot_t                      rot4_next;

    logic                               v4_reg;
    spw_pkg::rot_t                      rot4_reg;

    always_comb
    begin
        bearing_ext   = spw_pkg::BPROD_W'(bearing_deg);
        bprod_next    = spw_pkg::BPROD_W'(bearing_ext * spw_pkg::BPROD_W'(spw_pkg::DEG_TO_RAD_Q32));
        range_ext     = spw_pkg::RPROD_W'(range_dist);
        rprod         = spw_pkg::RPROD_W'(range_ext * spw_pkg::RPROD_W'(spw_pkg::INV_GAIN_Q30));
        side1_next.ok = (range_dist >= min_range);
        side1_next.rx = robot_x;
        side1_next.ry = robot_y;
        side1_next.rz = robot_z;
    end

    // The heading term is a multiple of 2^15, so it joins the sum ahead of the shift.
    always_comb
    begin
        hd_ext    = spw_pkg::BPROD_W'(hd1_reg);
        asum      = bprod_reg + spw_pkg::BEAR_RND + (hd_ext <<< 26);
        ang2_next = spw_pkg::ANG_W'(asum >>> 15);
    end

    always_comb
    begin
        if (ang2_reg > spw_pkg::ANG_PI)
        begin
            if (ang2_reg > spw_pkg::ANG_THREE_PI)
            begin
                ang3_next = ang2_reg - spw_pkg::ANG_FOUR_PI;
            end
            else
            begin
                ang3_next = ang2_reg - spw_pkg::ANG_TWO_PI;
            end
        end
        else if (ang2_reg < -spw_pkg::ANG_PI)
        begin
            if (ang2_reg < -spw_pkg::ANG_THREE_PI)
            begin
                ang3_next = ang2_reg + spw_pkg::ANG_FOUR_PI;
            end
            else
            begin
                ang3_next = ang2_reg + spw_pkg::ANG_TWO_PI;
            end
        end
        else
        begin
            ang3_next = ang2_reg;
        end
    end

    // Angles beyond a quarter turn flip the start vector and move by half a turn.
    always_comb
    begin
        x3_ext         = $signed(spw_pkg::XY_W'(x3_reg));
        rot4_next.y    = '0;
        rot4_next.side = side3_reg;
        if (ang3_reg > spw_pkg::ANG_HALF_PI)
        begin
            rot4_next.x   = -x3_ext;
            rot4_next.ang = ang3_reg - spw_pkg::ANG_PI;
        end
        else if (ang3_reg < -spw_pkg::ANG_HALF_PI)
        begin
            rot4_next.x   = -x3_ext;
            rot4_next.ang = ang3_reg + spw_pkg::ANG_PI;
        end
        else
        begin
            rot4_next.x   = x3_ext;
            rot4_next.ang = ang3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bprod_reg <= bprod_next;
            x1_reg    <= rprod[spw_pkg::RPROD_W-1:14];
            hd1_reg   <= heading;
            side1_reg <= side1_next;
            ang2_reg  <= ang2_next;
            x2_reg    <= x1_reg;
            side2_reg <= side1_reg;
            ang3_reg  <= ang3_next;
            x3_reg    <= x2_reg;
            side3_reg <= side2_reg;
            rot4_reg  <= rot4_next;
        end
    end

    assign out_v   = v4_reg;
    assign out_rot = rot4_reg;

    `SPW_ASSERT_NEXT(a_valid_moves, v1_reg && en, v2_reg, "request lost between first stages")
    `SPW_ASSERT(a_wrap_range, !v3_reg || (ang3_reg <= spw_pkg::ANG_PI && ang3_reg >= -spw_pkg::ANG_PI), "angle not wrapped")
    `SPW_ASSERT(a_quad_range, !v4_reg || (rot4_reg.ang <= (spw_pkg::ANG_PI - spw_pkg::ANG_HALF_PI) && rot4_reg.ang >= (spw_pkg::ANG_HALF_PI - spw_pkg::ANG_PI)), "angle outside rotation span")

endmodule

@@ hdl/spw_rot_stage.sv @@
module spw_rot_stage
#(
    parameter int STEP = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  spw_pkg::rot_t in_rot,
    output logic          out_v,
    output spw_pkg::rot_t out_rot
);

    logic signed [spw_pkg::XY_W-1:0]  dx;
    logic signed [spw_pkg::XY_W-1:0]  dy;
    logic signed [spw_pkg::ANG_W-1:0] atan_step;
    spw_pkg::rot_t                    rot_next;

    logic                             v_reg;
    spw_pkg::rot_t                    rot_reg;

    always_comb
    begin
        dx            = in_rot.y >>> STEP;
        dy            = in_rot.x >>> STEP;
        atan_step     = spw_pkg::atan_q24(spw_pkg::STEP_IDX_W'(STEP));
        rot_next.side = in_rot.side;
        if (in_rot.ang >= 0)
        begin
            rot_next.x   = in_rot.x - dx;
            rot_next.y   = in_rot.y + dy;
            rot_next.ang = in_rot.ang - atan_step;
        end
        else
        begin
            rot_next.x   = in_rot.x + dx;
            rot_next.y   = in_rot.y - dy;
            rot_next.ang = in_rot.ang + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign out_v   = v_reg;
    assign out_rot = rot_reg;

endmodule

@@ hdl/spw_back.sv @@
`include "assert_macros.svh"

module spw_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_v,
    input  spw_pkg::rot_t                       in_rot,
    input  logic [spw_pkg::CFG_W-1:0]           near_origin_limit,
    output logic                                out_valid,
    output logic signed [spw_pkg::COORD_W-1:0]  world_x,
    output logic signed [spw_pkg::COORD_W-1:0]  world_y,
    output logic signed [spw_pkg::COORD_W-1:0]  world_z,
    output logic                                valid_res,
    output logic                                map_keep
);

    logic signed [spw_pkg::XY_W-1:0]    xr;
    logic signed [spw_pkg::XY_W-1:0]    yr;

    logic                               va_reg;
    logic signed [spw_pkg::LOC_W-1:0]   lx_reg;
    logic signed [spw_pkg::LOC_W-1:0]   ly_reg;
    spw_pkg::side_t                     sidea_reg;

    logic signed [spw_pkg::SUM_W-1:0]   sx;
    logic signed [spw_pkg::SUM_W-1:0]   sy;
    logic signed [spw_pkg::SUM_W-1:0]   sx_sat;
    logic signed [spw_pkg::SUM_W-1:0]   sy_sat;
    logic signed [spw_pkg::SUM_W-1:0]   lim;
    logic                               keep;

    logic                               out_valid_reg;
    logic signed [spw_pkg::COORD_W-1:0] world_x_reg;
    logic signed [spw_pkg::COORD_W-1:0] world_y_reg;
    logic signed [spw_pkg::COORD_W-1:0] world_z_reg;
    logic                               valid_res_reg;
    logic                               map_keep_reg;

    always_comb
    begin
        xr = in_rot.x + spw_pkg::LOC_RND;
        yr = in_rot.y + spw_pkg::LOC_RND;
    end

    always_comb
    begin
        sx  = spw_pkg::SUM_W'(lx_reg) + spw_pkg::SUM_W'(sidea_reg.rx);
        sy  = spw_pkg::SUM_W'(ly_reg) + spw_pkg::SUM_W'(sidea_reg.ry);
        lim = $signed(spw_pkg::SUM_W'(near_origin_limit));
        if (sx > spw_pkg::SAT_MAX)
        begin
            sx_sat = spw_pkg::SAT_MAX;
        end
        else if (sx < spw_pkg::SAT_MIN)
        begin
            sx_sat = spw_pkg::SAT_MIN;
        end
        else
        begin
            sx_sat = sx;
        end
        if (sy > spw_pkg::SAT_MAX)
        begin
            sy_sat = spw_pkg::SAT_MAX;
        end
        else if (sy < spw_pkg::SAT_MIN)
        begin
            sy_sat = spw_pkg::SAT_MIN;
        end
        else
        begin
            sy_sat = sy;
        end
        keep = !(sx_sat < lim && sy_sat < lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= in_v;
            out_valid_reg <= va_reg;
        end
    end

    // A detection closer than the minimum range leaves an all-zero point.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx_reg    <= spw_pkg::LOC_W'(xr >>> 16);
            ly_reg    <= spw_pkg::LOC_W'(yr >>> 16);
            sidea_reg <= in_rot.side;
            if (sidea_reg.ok)
            begin
                world_x_reg   <= spw_pkg::COORD_W'(sx_sat);
                world_y_reg   <= spw_pkg::COORD_W'(sy_sat);
                world_z_reg   <= sidea_reg.rz;
                valid_res_reg <= 1'b1;
                map_keep_reg  <= keep;
            end
            else
            begin
                world_x_reg   <= '0;
                world_y_reg   <= '0;
                world_z_reg   <= '0;
                valid_res_reg <= 1'b0;
                map_keep_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign world_x   = world_x_reg;
    assign world_y   = world_y_reg;
    assign world_z   = world_z_reg;
    assign valid_res = valid_res_reg;
    assign map_keep  = map_keep_reg;

    `SPW_ASSERT(a_invalid_zero, !out_valid_reg || valid_res_reg || (world_x_reg == '0 && world_y_reg == '0 && world_z_reg == '0 && !map_keep_reg), "invalid point not cleared")
    `SPW_ASSERT(a_keep_needs_valid, !out_valid_reg || !map_keep_reg || valid_res_reg, "kept point marked invalid")

endmodule

@@ hdl/sonar_polar_to_world_unit.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid, in_stall   range_dist, bearing_deg, robot_x/y/z, heading
// out       output     out_valid, out_stall world_x, world_y, world_z, valid_res, map_keep
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One request enters per cycle while out_stall does not hold a waiting point.
// The pipeline is four front stages, one stage per rotation step, and two output stages.
// Reset clears the valid bits and loads min_range and near_origin_limit defaults.
// A stalled output freezes the whole pipeline, so in_stall follows out_stall while
// a point waits.

module sonar_polar_to_world_unit
#(
    parameter int ROTATION_STEPS = spw_pkg::ROTATION_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spw_pkg::RANGE_W-1:0]         range_dist,
    input  logic signed [spw_pkg::BEAR_W-1:0]   bearing_deg,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_x,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_y,
    input  logic signed [spw_pkg::COORD_W-1:0]  robot_z,
    input  logic signed [spw_pkg::HEAD_W-1:0]   heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spw_pkg::COORD_W-1:0]  world_x,
    output logic signed [spw_pkg::COORD_W-1:0]  world_y,
    output logic signed [spw_pkg::COORD_W-1:0]  world_z,
    output logic                                valid_res,
    output logic                                map_keep,
    input  logic                                cfg_we,
    input  logic [spw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spw_pkg::CFG_W-1:0]           cfg_data
);

    logic                        en;
    logic [spw_pkg::CFG_W-1:0]   min_range_reg;
    logic [spw_pkg::CFG_W-1:0]   near_origin_limit_reg;

    logic                        stage_v   [ROTATION_STEPS+1];
    spw_pkg::rot_t               stage_rot [ROTATION_STEPS+1];

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg         <= spw_pkg::MIN_RANGE_RST;
            near_origin_limit_reg <= spw_pkg::NEAR_ORIGIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spw_pkg::REG_MIN_RANGE:   min_range_reg         <= cfg_data;
                spw_pkg::REG_NEAR_ORIGIN: near_origin_limit_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    spw_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_v        (in_valid),
        .range_dist  (range_dist),
        .bearing_deg (bearing_deg),
        .robot_x     (robot_x),
        .robot_y     (robot_y),
        .robot_z     (robot_z),
        .heading     (heading),
        .min_range   (min_range_reg),
        .out_v       (stage_v[0]),
        .out_rot     (stage_rot[0])
    );

    for (genvar i = 0; i < ROTATION_STEPS; i++)
    begin : g_rot
        spw_rot_stage
        #(
            .STEP (i)
        )
        u_stage
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_v    (stage_v[i]),
            .in_rot  (stage_rot[i]),
            .out_v   (stage_v[i+1]),
            .out_rot (stage_rot[i+1])
        );
    end

    spw_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_v              (stage_v[ROTATION_STEPS]),
        .in_rot            (stage_rot[ROTATION_STEPS]),
        .near_origin_limit (near_origin_limit_reg),
        .out_valid         (out_valid),
        .world_x           (world_x),
        .world_y           (world_y),
        .world_z           (world_z),
        .valid_res         (valid_res),
        .map_keep          (map_keep)
    );

endmodule

@@ test/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spw_pkg::*;

    localparam int    STEPS      = ROTATION_STEPS_DEF;
    localparam int    LONG_HOLD  = 300;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        [RANGE_W-1:0] range_dist;
        logic signed [BEAR_W-1:0]  bearing_deg;
        logic signed [COORD_W-1:0] robot_x;
        logic signed [COORD_W-1:0] robot_y;
        logic signed [COORD_W-1:0] robot_z;
        logic signed [HEAD_W-1:0]  heading;
    } detection_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
        logic                      valid_res;
        logic                      map_keep;
    } point_t;

    class point_scoreboard;
        localparam longint BEAR_TO_RAD = 74961321;
        localparam longint GAIN_COMP   = 652032874;
        localparam longint HALF_TURN   = 52707179;
        localparam longint QUARTER     = 26353589;
        localparam longint COORD_TOP   = 8388607;
        localparam longint COORD_BOT   = -8388608;

        point_t pending_points[$];
        longint min_range;
        longint near_limit;
        longint atan_tab[24];
        int     failures;

        function new();
            min_range  = 26;
            near_limit = 51;
            failures   = 0;
            atan_tab   = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                           131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == REG_MIN_RANGE)
                min_range = longint'(value);
            else if (idx == REG_NEAR_ORIGIN)
                near_limit = longint'(value);
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_TOP)
                return COORD_TOP;
            if (v < COORD_BOT)
                return COORD_BOT;
            return v;
        endfunction

        function point_t predict_point(detection_t d);
            point_t p;
            longint ang;
            longint x;
            longint y;
            longint dx;
            longint dy;
            longint wx;
            longint wy;
            p = '0;
            if (longint'(d.range_dist) < min_range)
                return p;
            ang = (longint'($signed(d.bearing_deg)) * BEAR_TO_RAD + 64'sd16384) >>> 15;
            ang = ang + longint'($signed(d.heading)) * 2048;
            while (ang > HALF_TURN)
                ang = ang - 2 * HALF_TURN;
            while (ang < -HALF_TURN)
                ang = ang + 2 * HALF_TURN;
            x = (longint'(d.range_dist) * GAIN_COMP) >>> 14;
            y = 0;
            if (ang > QUARTER)
            begin
                x = -x;
                ang = ang - HALF_TURN;
            end
            else if (ang < -QUARTER)
            begin
                x = -x;
                ang = ang + HALF_TURN;
            end
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (ang >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    ang = ang - atan_tab[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    ang = ang + atan_tab[i];
                end
            end
            wx = clamp_coord(((x + 64'sd32768) >>> 16) + longint'($signed(d.robot_x)));
            wy = clamp_coord(((y + 64'sd32768) >>> 16) + longint'($signed(d.robot_y)));
            p.world_x   = wx[COORD_W-1:0];
            p.world_y   = wy[COORD_W-1:0];
            p.world_z   = d.robot_z;
            p.valid_res = 1'b1;
            p.map_keep  = !(wx < near_limit && wy < near_limit);
            return p;
        endfunction

        function void note_request(detection_t d);
            pending_points.push_back(predict_point(d));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                $error("%s expected %0d actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending_points.size() == 0)
            begin
                $error("point with no request waiting: world_x %0d world_y %0d",
                       got.world_x, got.world_y);
                failures++;
                return;
            end
            want = pending_points.pop_front();
            compare_field("world_x", $signed(want.world_x), $signed(got.world_x));
            compare_field("world_y", $signed(want.world_y), $signed(got.world_y));
            compare_field("world_z", $signed(want.world_z), $signed(got.world_z));
            compare_field("valid_res", want.valid_res, got.valid_res);
            compare_field("map_keep", want.map_keep, got.map_keep);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic        [RANGE_W-1:0]   range_dist;
    logic signed [BEAR_W-1:0]    bearing_deg;
    logic signed [COORD_W-1:0]   robot_x;
    logic signed [COORD_W-1:0]   robot_y;
    logic signed [COORD_W-1:0]   robot_z;
    logic signed [HEAD_W-1:0]    heading;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [COORD_W-1:0]   world_x;
    logic signed [COORD_W-1:0]   world_y;
    logic signed [COORD_W-1:0]   world_z;
    logic                        valid_res;
    logic                        map_keep;
    logic                        cfg_we;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [CFG_W-1:0]     cfg_data;

    point_scoreboard sb = new();
    point_t          seen_point;
    bit              hold_off = 1'b0;
    longint          cycles = 0;

    sonar_polar_to_world_unit #(.ROTATION_STEPS(STEPS)) u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .range_dist  (range_dist),
        .bearing_deg (bearing_deg),
        .robot_x     (robot_x),
        .robot_y     (robot_y),
        .robot_z     (robot_z),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .world_x     (world_x),
        .world_y     (world_y),
        .world_z     (world_z),
        .valid_res   (valid_res),
        .map_keep    (map_keep),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_point.world_x   = world_x;
            seen_point.world_y   = world_y;
            seen_point.world_z   = world_z;
            seen_point.valid_res = valid_res;
            seen_point.map_keep  = map_keep;
            sb.check_point(seen_point);
        end
    end

    initial
    begin
        int       mode;
        int       span;
        bit [7:0] pat;
        mode = 0;
        span = 0;
        pat  = '0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 128);
                    pat  = 8'($urandom);
                end
                span--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        out_stall <= pat[0];
                        pat = {pat[0], pat[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic detection_t make_detection(int r, int b, int x, int y, int z, int h);
        detection_t d;
        d.range_dist  = RANGE_W'(r);
        d.bearing_deg = BEAR_W'(b);
        d.robot_x     = COORD_W'(x);
        d.robot_y     = COORD_W'(y);
        d.robot_z     = COORD_W'(z);
        d.heading     = HEAD_W'(h);
        return d;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic detection_t random_detection(longint min_r);
        detection_t d;
        int         pick;
        longint     r;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            r = $urandom_range(0, 65535);
        else if (pick == 3)
        begin
            r = min_r + longint'($urandom_range(0, 4)) - 2;
            if (r < 0)
                r = 0;
            if (r > 65535)
                r = 65535;
        end
        else
            r = $urandom_range(0, 4096);
        d.range_dist = RANGE_W'(r);
        if ($urandom_range(0, 9) == 0)
            d.bearing_deg = BEAR_W'($urandom);
        else
            d.bearing_deg = BEAR_W'(int'($urandom_range(0, 92160)) - 46080);
        d.robot_x = random_coord();
        d.robot_y = random_coord();
        d.robot_z = random_coord();
        d.heading = HEAD_W'($urandom);
        return d;
    endfunction

    task automatic send_request(detection_t d);
        in_valid    <= 1'b1;
        range_dist  <= d.range_dist;
        bearing_deg <= d.bearing_deg;
        robot_x     <= d.robot_x;
        robot_y     <= d.robot_y;
        robot_z     <= d.robot_z;
        heading     <= d.heading;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(d);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (STEPS + 10) @(posedge clk);
    endtask

    task automatic run_random(int n, bit steady);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            burst = steady ? left : $urandom_range(1, 40);
            if (burst > left)
                burst = left;
            repeat (burst) send_request(random_detection(sb.min_range));
            left -= burst;
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        send_request(make_detection(0, 0, 0, 0, 0, 0));
        send_request(make_detection(25, 0, 1000, 1000, 1000, 0));
        send_request(make_detection(26, 0, 0, 0, 0, 0));
        send_request(make_detection(65535, 0, 0, 0, 0, 0));
        send_request(make_detection(65535, 0, 8388607, 0, 0, 0));
        send_request(make_detection(65535, 23040, -8388608, 0, 0, 0));
        send_request(make_detection(65535, 11520, 0, 8388607, 0, 0));
        send_request(make_detection(65535, -11520, 0, -8388608, 0, 0));
        send_request(make_detection(1000, 11520, 0, 0, 0, 0));
        send_request(make_detection(1000, -11520, 0, 0, 0, 0));
        send_request(make_detection(1000, 46080, 0, 0, 0, 0));
        send_request(make_detection(1000, -46080, 0, 0, 0, 0));
        send_request(make_detection(2000, 65535, 500, 500, 0, 0));
        send_request(make_detection(2000, -65536, 500, 500, 0, 0));
        send_request(make_detection(3000, 46080, 0, 0, 0, 32767));
        send_request(make_detection(3000, -46080, 0, 0, 0, -32768));
        send_request(make_detection(100, 0, -1000, -1000, 0, 0));
        send_request(make_detection(0, 0, 0, 0, 8388607, 0));
        send_request(make_detection(500, 0, 0, 0, -8388608, 0));
        send_request(make_detection(30000, 5760, 100, -100, 8388607, 0));
        send_request(make_detection(25, 23040, -8388608, 8388607, -8388608, -32768));
        send_request(make_detection(4000, -5760, 20000, -20000, 777, 12345));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [CFG_W-1:0] new_min;
        logic [CFG_W-1:0] new_near;
        in_valid    <= 1'b0;
        range_dist  <= '0;
        bearing_deg <= '0;
        robot_x     <= '0;
        robot_y     <= '0;
        robot_z     <= '0;
        heading     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_MIN_RANGE;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(250, 1'b0);
        wait_idle();

        for (int p = 1; p <= 7; p++)
        begin
            case (p)
                1:
                begin
                    new_min  = 16'd0;
                    new_near = 16'd0;
                end
                2:
                begin
                    new_min  = 16'hFFFF;
                    new_near = 16'hFFFF;
                end
                3:
                begin
                    new_min  = 16'd0;
                    new_near = 16'hFFFF;
                end
                4:
                begin
                    new_min  = 16'd26;
                    new_near = 16'd51;
                end
                5:
                begin
                    new_min  = 16'hFFFF;
                    new_near = 16'd0;
                end
                6:
                begin
                    new_min  = CFG_W'($urandom_range(0, 2048));
                    new_near = CFG_W'($urandom_range(0, 4096));
                end
                default:
                begin
                    new_min  = CFG_W'($urandom);
                    new_near = CFG_W'($urandom);
                end
            endcase
            write_reg(REG_MIN_RANGE, new_min);
            write_reg(REG_NEAR_ORIGIN, new_near);
            if (p == 4)
                hold_off = 1'b1;
            run_random(250, p == 3);
            wait_idle();
        end

        if (sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
